[sv/lane_session_job_dispatcher_top_assert.svh]
// assertion macros for the dispatcher top level
`ifndef LANE_SESSION_JOB_DISPATCHER_TOP_ASSERT_SVH
`define LANE_SESSION_JOB_DISPATCHER_TOP_ASSERT_SVH

// invariant checked at every clock edge out of reset
`define LSJD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define LSJD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[sv/lsjd_pkg.sv]
// shared types, codes and helpers of the lane session job dispatcher
package lsjd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_JWAIT,
		ST_JEXE,
		ST_SWAIT,
		ST_SEXE,
		ST_MWAIT,
		ST_MEXE,
		ST_DCHK
	} state_t;

	typedef enum logic [2:0] {
		JM_COUNT,
		JM_CUT,
		JM_FIND,
		JM_DISP,
		JM_SHIFT
	} jmode_t;

	localparam logic [2:0] REQ_SUBMIT   = 3'd0;
	localparam logic [2:0] REQ_DISPATCH = 3'd1;
	localparam logic [2:0] REQ_FINISH   = 3'd2;
	localparam logic [2:0] REQ_INT_SESS = 3'd3;
	localparam logic [2:0] REQ_INT_RUN  = 3'd4;
	localparam logic [2:0] REQ_COLLECT  = 3'd5;

	localparam logic [1:0] ACT_STEER     = 2'd0;
	localparam logic [1:0] ACT_FOLLOWUP  = 2'd1;
	localparam logic [1:0] ACT_COLLECT   = 2'd2;
	localparam logic [1:0] ACT_INTERRUPT = 2'd3;

	localparam logic [1:0] JS_PENDING = 2'd0;
	localparam logic [1:0] JS_RUNNING = 2'd1;
	localparam logic [1:0] JS_DONE    = 2'd2;

	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_INVALID     = 3'd1;
	localparam logic [2:0] STAT_PENDING_CAP = 3'd2;
	localparam logic [2:0] STAT_FULL        = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND   = 3'd4;
	localparam logic [2:0] STAT_NONE_RUN    = 3'd5;
	localparam logic [2:0] STAT_NOT_DONE    = 3'd6;

	localparam logic [2:0] CFG_MAIN_LANE     = 3'd0;
	localparam logic [2:0] CFG_SUBAGENT_LANE = 3'd1;
	localparam logic [2:0] CFG_PLUGIN_LANE   = 3'd2;
	localparam logic [2:0] CFG_TOOL_LANE     = 3'd3;
	localparam logic [2:0] CFG_SESS_RUN      = 3'd4;
	localparam logic [2:0] CFG_SESS_CAP      = 3'd5;

	function automatic logic [5:0] norm_limit(input logic [5:0] v);
		return (v == 6'd0) ? 6'd1 : v;
	endfunction

endpackage

[sv/lane_session_job_dispatcher_top.sv]
// top level of the lane session job dispatcher: sequencer, counters and tables
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  request   | start, busy               | req_type session_id lane_sel action_kind run_id
//  result    | done (one-cycle strobe)   | status run_id_out session_out lane_out
//            |                           | cancelled in_flight_total pending_total
//  config    | cfg_valid, cfg_ready      | cfg_index cfg_data
//
// one request walks the job table one entry at a time through the single job ram read port,
// a wait state and an execute state per entry; dispatch and finish add a session table walk
// with a wait state and an execute state per slot
// bad ids, bad lanes and unknown types are answered from the idle state without a table walk
// asynchronous reset empties both tables at once; no clearing pass
// results cannot be stalled: done is high for exactly one cycle
module lane_session_job_dispatcher_top #(
	parameter int JOB_SLOTS     = 64,
	parameter int SESSION_SLOTS = 128,
	parameter int LANES         = 4,
	parameter int SESSION_BITS  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [9:0]  session_id,
	input  logic [1:0]  lane_sel,
	input  logic [1:0]  action_kind,
	input  logic [15:0] run_id,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] run_id_out,
	output logic [9:0]  session_out,
	output logic [1:0]  lane_out,
	output logic        cancelled,
	output logic [6:0]  in_flight_total,
	output logic [6:0]  pending_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import lsjd_pkg::*;

	localparam int SB = SESSION_BITS;
	localparam int JA = $clog2(JOB_SLOTS);
	localparam int JC = $clog2(JOB_SLOTS + 1);
	localparam int SA = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
	localparam int SC = $clog2(SESSION_SLOTS + 1);
	localparam int JW = SB + 21;
	localparam int SW = SB + 6;

	state_t state_q, state_d;
	jmode_t mode_q, mode_d;

	logic [2:0]  req_q;
	logic [SB-1:0] sess_q;
	logic [1:0]  lane_q, act_q;
	logic [15:0] id_q;

	logic [JC-1:0] idx_q, idx_d, pend_q, pend_d, count_q, count_d;
	logic [JC-1:0] running_q, run_d, waiting_q, wait_d;
	logic [JC-1:0] lane_busy_q [LANES];
	logic [JC-1:0] lb_d [LANES];
	logic [SC-1:0] sidx_q, sidx_d, scount_q, scount_d, sslot_q, sslot_d;
	logic [5:0]    sbusy_q, sbusy_d;
	logic [JW-1:0] jreg_q, jreg_d;
	logic [15:0]   nid_q, nid_d;
	logic [5:0]    lim_q [4];
	logic [5:0]    run_lim_q;
	logic [6:0]    cap_q;

	logic          done_q;
	logic [2:0]    status_q;
	logic [15:0]   oid_q;
	logic [SB-1:0] osess_q;
	logic [1:0]    olane_q;
	logic          ocanc_q;

	logic          jwe, swe;
	logic [JA-1:0] jwa, jra;
	logic [SA-1:0] swa, sra;
	logic [JW-1:0] jwd, jrd;
	logic [SW-1:0] swd, srd;

	logic          fin, show_raw, show_reg, do_append, canc_set;
	logic [2:0]    o_status;
	logic [15:0]   o_id;
	logic [SB-1:0] o_sess;
	logic [1:0]    o_lane;
	logic          o_canc;

	logic [15:0]   j_id, r_id;
	logic [SB-1:0] j_sess, r_sess, s_sess, sess_in;
	logic [1:0]    j_lane, r_lane, j_st;
	logic          j_canc, r_canc;
	logic [5:0]    s_busy, s_nb;
	logic [SB+9:0] sess_wide, osess_wide;
	logic [JC:0]   idx_p1;
	logic [SC-1:0] scount_m1;
	logic [JC-1:0] lb_cur;
	logic [JC+6:0] run_wide, wait_wide;

	logic go, scan_end, full, sess_full, cap_hit, lane_in_ok, lane_r_ok, run_ok;
	logic j_pend, j_run, j_done, j_smatch, j_idmatch, cut_p, cut_r, s_end, s_match;
	logic is_last;

	lsjd_ram #(.WIDTH(JW), .DEPTH(JOB_SLOTS)) u_job_ram (
		.clk(clk), .we(jwe), .waddr(jwa), .wdata(jwd), .raddr(jra), .rdata(jrd)
	);

	lsjd_ram #(.WIDTH(SW), .DEPTH(SESSION_SLOTS)) u_sess_ram (
		.clk(clk), .we(swe), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd)
	);

	assign sess_wide = {{SB{1'b0}}, session_id};
	assign sess_in   = sess_wide[SB-1:0];

	assign j_canc = jrd[0];
	assign j_st   = jrd[2:1];
	assign j_lane = jrd[4:3];
	assign j_sess = jrd[SB+4:5];
	assign j_id   = jrd[SB+20:SB+5];
	assign r_canc = jreg_q[0];
	assign r_lane = jreg_q[4:3];
	assign r_sess = jreg_q[SB+4:5];
	assign r_id   = jreg_q[SB+20:SB+5];
	assign s_busy = srd[5:0];
	assign s_sess = srd[SB+5:6];
	assign s_nb   = (s_busy == 6'd0) ? 6'd0 : s_busy - 6'd1;

	assign go        = (state_q == ST_IDLE) && start;
	assign idx_p1    = {1'b0, idx_q} + (JC+1)'(1);
	assign scan_end  = (mode_q == JM_SHIFT) ? (idx_p1 >= {1'b0, count_q}) : (idx_q >= count_q);
	assign full      = count_q >= JC'(JOB_SLOTS);
	assign sess_full = scount_q >= SC'(SESSION_SLOTS);
	assign cap_hit   = (cap_q != 7'd0) && ((JC+7)'(pend_q) >= (JC+7)'(cap_q));
	assign lane_in_ok = 32'(lane_sel) < LANES;
	assign lane_r_ok  = 32'(r_lane) < LANES;
	assign j_pend    = j_st == JS_PENDING;
	assign j_run     = j_st == JS_RUNNING;
	assign j_done    = j_st == JS_DONE;
	assign j_smatch  = j_sess == sess_q;
	assign j_idmatch = j_id == id_q;
	assign cut_p     = (req_q == REQ_INT_SESS) || (act_q != ACT_FOLLOWUP);
	assign cut_r     = (req_q == REQ_INT_SESS) || (act_q == ACT_STEER) || (act_q == ACT_INTERRUPT);
	assign s_end     = sidx_q >= scount_q;
	assign s_match   = s_sess == r_sess;
	assign scount_m1 = scount_q - SC'(1);
	assign is_last   = sidx_q == scount_m1;

	assign jra = (mode_q == JM_SHIFT) ? idx_p1[JA-1:0] : idx_q[JA-1:0];
	assign sra = (state_q == ST_MWAIT) ? scount_m1[SA-1:0] : sidx_q[SA-1:0];

	always_comb begin
		lb_cur = '0;
		for (int l = 0; l < LANES; l++) begin
			if (32'(r_lane) == l) begin
				lb_cur = lane_busy_q[l];
			end
		end
	end

	assign run_ok = lane_r_ok && (sbusy_q < norm_limit(run_lim_q)) &&
		((JC+6)'(lb_cur) < (JC+6)'(norm_limit(lim_q[r_lane])));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go && !fin) state_d = ST_JWAIT;
			end
			ST_JWAIT: begin
				if (fin) state_d = ST_IDLE;
				else if (!scan_end) state_d = ST_JEXE;
			end
			ST_JEXE: begin
				if (fin) state_d = ST_IDLE;
				else if (mode_q == JM_FIND && j_idmatch && req_q == REQ_FINISH) state_d = ST_SWAIT;
				else if (mode_q == JM_DISP && j_pend) state_d = ST_SWAIT;
				else state_d = ST_JWAIT;
			end
			ST_SWAIT: begin
				if (fin) state_d = ST_IDLE;
				else if (s_end) state_d = sess_full ? ST_JWAIT : ST_DCHK;
				else state_d = ST_SEXE;
			end
			ST_SEXE: begin
				if (fin) state_d = ST_IDLE;
				else if (s_match) state_d = (req_q == REQ_DISPATCH) ? ST_DCHK : ST_MWAIT;
				else state_d = ST_SWAIT;
			end
			ST_MWAIT: state_d = ST_MEXE;
			ST_MEXE:  state_d = ST_IDLE;
			ST_DCHK:  state_d = fin ? ST_IDLE : ST_JWAIT;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath, table writes and result
	always_comb begin
		idx_d = idx_q; sidx_d = sidx_q; pend_d = pend_q; jreg_d = jreg_q;
		sslot_d = sslot_q; sbusy_d = sbusy_q; count_d = count_q; scount_d = scount_q;
		run_d = running_q; wait_d = waiting_q; lb_d = lane_busy_q; nid_d = nid_q;
		mode_d = mode_q;
		jwe = 1'b0; jwa = idx_q[JA-1:0]; jwd = jrd;
		swe = 1'b0; swa = sidx_q[SA-1:0]; swd = srd;
		fin = 1'b0; show_raw = 1'b0; show_reg = 1'b0; do_append = 1'b0; canc_set = 1'b0;
		o_status = STAT_OK; o_id = '0; o_sess = '0; o_lane = '0; o_canc = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					idx_d = '0;
					pend_d = '0;
					case (req_type) inside
						REQ_SUBMIT: begin
							if (!lane_in_ok) begin
								fin = 1'b1; o_status = STAT_INVALID;
							end else if (action_kind == ACT_FOLLOWUP ||
								action_kind == ACT_INTERRUPT) begin
								mode_d = JM_COUNT;
							end else if (full) begin
								fin = 1'b1; o_status = STAT_FULL;
							end else begin
								mode_d = JM_CUT;
							end
						end
						REQ_DISPATCH: mode_d = JM_DISP;
						REQ_FINISH, REQ_INT_RUN, REQ_COLLECT: begin
							if (run_id == 16'd0) begin
								fin = 1'b1; o_status = STAT_INVALID;
							end else begin
								mode_d = JM_FIND;
							end
						end
						REQ_INT_SESS: mode_d = JM_CUT;
						default: begin
							fin = 1'b1; o_status = STAT_INVALID;
						end
					endcase
				end
			end
			ST_JWAIT: begin
				if (scan_end) begin
					case (mode_q)
						JM_COUNT: begin
							if (cap_hit) begin
								fin = 1'b1; o_status = STAT_PENDING_CAP;
							end else if (full) begin
								fin = 1'b1; o_status = STAT_FULL;
							end else if (act_q == ACT_FOLLOWUP) begin
								do_append = 1'b1;
							end else begin
								mode_d = JM_CUT; idx_d = '0;
							end
						end
						JM_CUT: begin
							if (req_q == REQ_SUBMIT) begin
								do_append = 1'b1;
							end else begin
								fin = 1'b1; o_sess = sess_q;
							end
						end
						JM_FIND: begin
							fin = 1'b1; o_status = STAT_NOT_FOUND;
						end
						JM_DISP: begin
							fin = 1'b1; o_status = STAT_NONE_RUN;
						end
						JM_SHIFT: begin
							count_d = count_q - JC'(1);
							fin = 1'b1; show_reg = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_JEXE: begin
				case (mode_q)
					JM_COUNT: begin
						if (j_pend && j_smatch) pend_d = pend_q + JC'(1);
						idx_d = idx_q + JC'(1);
					end
					JM_CUT: begin
						if (j_smatch && cut_p && j_pend) begin
							jwe = 1'b1;
							jwd = {j_id, j_sess, j_lane, JS_DONE, 1'b1};
							if (waiting_q != '0) wait_d = waiting_q - JC'(1);
						end else if (j_smatch && cut_r && j_run) begin
							jwe = 1'b1;
							jwd = {j_id, j_sess, j_lane, j_st, 1'b1};
						end
						idx_d = idx_q + JC'(1);
					end
					JM_FIND: begin
						if (!j_idmatch) begin
							idx_d = idx_q + JC'(1);
						end else begin
							case (req_q)
								REQ_FINISH: begin
									if (!j_run) begin
										fin = 1'b1; o_status = STAT_NOT_FOUND; show_raw = 1'b1;
									end else begin
										jwe = 1'b1;
										jwd = {j_id, j_sess, j_lane, JS_DONE, j_canc};
										for (int l = 0; l < LANES; l++) begin
											if (32'(j_lane) == l && lane_busy_q[l] != '0)
												lb_d[l] = lane_busy_q[l] - JC'(1);
										end
										if (running_q != '0) run_d = running_q - JC'(1);
										jreg_d = jrd;
										sidx_d = '0;
									end
								end
								REQ_INT_RUN: begin
									if (j_pend) begin
										jwe = 1'b1;
										jwd = {j_id, j_sess, j_lane, JS_DONE, 1'b1};
										if (waiting_q != '0) wait_d = waiting_q - JC'(1);
									end else if (j_run) begin
										jwe = 1'b1;
										jwd = {j_id, j_sess, j_lane, j_st, 1'b1};
									end
									canc_set = j_pend || j_run;
									fin = 1'b1; show_raw = 1'b1;
								end
								REQ_COLLECT: begin
									if (!j_done) begin
										fin = 1'b1; o_status = STAT_NOT_DONE; show_raw = 1'b1;
									end else begin
										jreg_d = jrd;
										mode_d = JM_SHIFT;
									end
								end
								default: ;
							endcase
						end
					end
					JM_DISP: begin
						if (j_pend) begin
							jreg_d = jrd;
							sidx_d = '0;
						end else begin
							idx_d = idx_q + JC'(1);
						end
					end
					JM_SHIFT: begin
						jwe = 1'b1;
						jwd = jrd;
						idx_d = idx_q + JC'(1);
					end
					default: ;
				endcase
			end
			ST_SWAIT: begin
				if (s_end) begin
					if (req_q == REQ_DISPATCH) begin
						if (sess_full) begin
							jwe = 1'b1;
							jwd = {r_id, r_sess, r_lane, JS_DONE, 1'b1};
							if (waiting_q != '0) wait_d = waiting_q - JC'(1);
							idx_d = idx_q + JC'(1);
						end else begin
							swe = 1'b1;
							swa = scount_q[SA-1:0];
							swd = {r_sess, 6'd0};
							sslot_d = scount_q;
							sbusy_d = 6'd0;
							scount_d = scount_q + SC'(1);
						end
					end else begin
						fin = 1'b1; show_reg = 1'b1;
					end
				end
			end
			ST_SEXE: begin
				if (s_match) begin
					if (req_q == REQ_DISPATCH) begin
						sslot_d = sidx_q;
						sbusy_d = s_busy;
					end else if (s_nb == 6'd0) begin
						if (!is_last) begin
							sslot_d = sidx_q;
						end else begin
							scount_d = scount_m1;
							fin = 1'b1; show_reg = 1'b1;
						end
					end else begin
						swe = 1'b1;
						swd = {s_sess, s_nb};
						fin = 1'b1; show_reg = 1'b1;
					end
				end else begin
					sidx_d = sidx_q + SC'(1);
				end
			end
			ST_MWAIT: ;
			ST_MEXE: begin
				swe = 1'b1;
				swa = sslot_q[SA-1:0];
				swd = srd;
				scount_d = scount_m1;
				fin = 1'b1; show_reg = 1'b1;
			end
			ST_DCHK: begin
				if (run_ok) begin
					swe = 1'b1;
					swa = sslot_q[SA-1:0];
					swd = {r_sess, sbusy_q + 6'd1};
					for (int l = 0; l < LANES; l++) begin
						if (32'(r_lane) == l) lb_d[l] = lane_busy_q[l] + JC'(1);
					end
					run_d = running_q + JC'(1);
					if (waiting_q != '0) wait_d = waiting_q - JC'(1);
					jwe = 1'b1;
					jwd = {r_id, r_sess, r_lane, JS_RUNNING, r_canc};
					fin = 1'b1; show_reg = 1'b1;
				end else begin
					idx_d = idx_q + JC'(1);
				end
			end
			default: ;
		endcase
		if (do_append) begin
			jwe = 1'b1;
			jwa = count_q[JA-1:0];
			jwd = {nid_q, sess_q, lane_q, JS_PENDING, 1'b0};
			count_d = count_q + JC'(1);
			nid_d = (nid_q == 16'hFFFF) ? 16'd1 : nid_q + 16'd1;
			wait_d = waiting_q + JC'(1);
			fin = 1'b1;
			o_id = nid_q; o_sess = sess_q; o_lane = lane_q;
		end
		if (show_raw) begin
			o_id = j_id; o_sess = j_sess; o_lane = j_lane; o_canc = j_canc || canc_set;
		end
		if (show_reg) begin
			o_id = r_id; o_sess = r_sess; o_lane = r_lane; o_canc = r_canc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= JM_COUNT;
			idx_q     <= '0;
			sidx_q    <= '0;
			pend_q    <= '0;
			sslot_q   <= '0;
			sbusy_q   <= '0;
			count_q   <= '0;
			scount_q  <= '0;
			running_q <= '0;
			waiting_q <= '0;
			nid_q     <= 16'd1;
			for (int l = 0; l < LANES; l++) lane_busy_q[l] <= '0;
			lim_q[0]  <= 6'd4;
			lim_q[1]  <= 6'd8;
			lim_q[2]  <= 6'd4;
			lim_q[3]  <= 6'd4;
			run_lim_q <= 6'd1;
			cap_q     <= 7'd20;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			idx_q     <= idx_d;
			sidx_q    <= sidx_d;
			pend_q    <= pend_d;
			sslot_q   <= sslot_d;
			sbusy_q   <= sbusy_d;
			count_q   <= count_d;
			scount_q  <= scount_d;
			running_q <= run_d;
			waiting_q <= wait_d;
			nid_q     <= nid_d;
			lane_busy_q <= lb_d;
			done_q    <= fin;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAIN_LANE:     lim_q[0]  <= cfg_data[5:0];
					CFG_SUBAGENT_LANE: lim_q[1]  <= cfg_data[5:0];
					CFG_PLUGIN_LANE:   lim_q[2]  <= cfg_data[5:0];
					CFG_TOOL_LANE:     lim_q[3]  <= cfg_data[5:0];
					CFG_SESS_RUN:      run_lim_q <= cfg_data[5:0];
					CFG_SESS_CAP:      cap_q     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		jreg_q <= jreg_d;
		if (go) begin
			req_q  <= req_type;
			sess_q <= sess_in;
			lane_q <= lane_sel;
			act_q  <= action_kind;
			id_q   <= run_id;
		end
		if (fin) begin
			status_q <= o_status;
			oid_q    <= o_id;
			osess_q  <= o_sess;
			olane_q  <= o_lane;
			ocanc_q  <= o_canc;
		end
	end

	assign osess_wide = {10'd0, osess_q};
	assign run_wide   = {7'd0, running_q};
	assign wait_wide  = {7'd0, waiting_q};

	assign busy            = state_q != ST_IDLE;
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign status          = status_q;
	assign run_id_out      = oid_q;
	assign session_out     = osess_wide[9:0];
	assign lane_out        = olane_q;
	assign cancelled       = ocanc_q;
	assign in_flight_total = run_wide[6:0];
	assign pending_total   = wait_wide[6:0];

`include "lane_session_job_dispatcher_top_assert.svh"

	`LSJD_ASSERT_ALWAYS(a_job_count_bound, count_q <= JC'(JOB_SLOTS), "job count past table size")
	`LSJD_ASSERT_ALWAYS(a_sess_count_bound, scount_q <= SC'(SESSION_SLOTS), "session count past table")
	`LSJD_ASSERT_ALWAYS(a_totals_fit, ((JC+1)'(running_q) + (JC+1)'(waiting_q)) <= (JC+1)'(count_q), "totals exceed jobs")
	`LSJD_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE, "result strobe while sequencer busy")

endmodule

[sv/lsjd_ram.sv]
// generic single write port ram with registered read
module lsjd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
